[hdl/sclf_pkg.sv]
// Shared types, character codes and helpers for the serial command line framer.
package sclf_pkg;

    localparam int LEN_W = 7;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_SEND
    } ctrl_state_t;

    typedef struct packed {
        logic byte_en;
        logic read_start;
        logic advance;
        logic send_char;
    } ctrl_cmd_t;

    typedef struct packed {
        logic read_single;
        logic last_char;
    } dp_status_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

endpackage

[hdl/sclf_dpath.sv]
// Datapath: line memory (two banks), assembly counters, read counters, result fields.
module sclf_dpath import sclf_pkg::*; #(
    parameter int FRAME_MAX = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ctrl_cmd_t        cmd,
    input  logic [15:0]      s_tdata,
    output dp_status_t       status,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int IW = $clog2(FRAME_MAX);
    localparam int AW = IW + 1;
    localparam logic [IW-1:0] FILL_MAX = IW'(FRAME_MAX - 1);

    // two banks: one assembles, the other holds the published line
    logic [7:0] mem [0:(1 << AW) - 1];

    logic [IW-1:0]    fill_reg, fill_next;
    logic [IW-1:0]    clean_reg, clean_next;
    logic [IW-1:0]    rlen_reg, rlen_next;
    logic             ovf_reg, ovf_next;
    logic             ready_reg, ready_next;
    logic             bank_reg, bank_next;
    logic [7:0]       c0_reg, c0_next;
    logic [7:0]       c1_reg, c1_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             hf_reg, hf_next;
    logic [7:0]       rdata_reg;

    logic [7:0]       rx_b;
    logic [7:0]       limit;
    logic [7:0]       limit_m1;
    logic [7:0]       n_val;
    logic             wr_en;
    logic             is_short;
    logic [IW-1:0]    fill_inc;
    logic [IW-1:0]    clean_inc;

    assign rx_b     = s_tdata[7:0];
    assign limit    = s_tdata[15:8];
    assign limit_m1 = limit - 8'd1;
    assign n_val    = (limit_m1 < 8'(rlen_reg)) ? limit_m1 : 8'(rlen_reg);
    assign fill_inc = fill_reg + IW'(1);
    assign clean_inc = (clean_reg == fill_reg && rx_b != 8'd0) ? clean_reg + IW'(1)
                                                               : clean_reg;

    always_comb begin
        is_short = 1'b0;
        if (fill_reg == IW'(0)) begin
            is_short = (to_upper(rx_b) == CH_U) || (to_upper(rx_b) == CH_L) ||
                       (to_upper(rx_b) == CH_S);
        end else if (fill_reg == IW'(2)) begin
            is_short = (to_upper(c0_reg) == CH_P) && (c1_reg == CH_COMMA) &&
                       (rx_b >= CH_ZERO) && (rx_b <= CH_NINE);
        end
    end

    // byte intake and read bookkeeping
    always_comb begin
        fill_next  = fill_reg;
        clean_next = clean_reg;
        rlen_next  = rlen_reg;
        ovf_next   = ovf_reg;
        ready_next = ready_reg;
        bank_next  = bank_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        hf_next    = hf_reg;
        wr_en      = 1'b0;
        if (cmd.byte_en && !ready_reg) begin
            if (rx_b == CH_CR || rx_b == CH_LF) begin
                if (!ovf_reg && fill_reg != IW'(0)) begin
                    ready_next = 1'b1;
                    rlen_next  = clean_reg;
                    bank_next  = !bank_reg;
                end
                fill_next  = '0;
                clean_next = '0;
                ovf_next   = 1'b0;
            end else if (!ovf_reg) begin
                if (fill_reg < FILL_MAX) begin
                    wr_en = 1'b1;
                    if (fill_reg == IW'(0)) c0_next = rx_b;
                    if (fill_reg == IW'(1)) c1_next = rx_b;
                    if (is_short) begin
                        ready_next = 1'b1;
                        rlen_next  = clean_inc;
                        bank_next  = !bank_reg;
                        fill_next  = '0;
                        clean_next = '0;
                    end else begin
                        fill_next  = fill_inc;
                        clean_next = clean_inc;
                    end
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end
        if (cmd.read_start) begin
            idx_next = '0;
            if (limit == 8'd0 || !ready_reg) begin
                hf_next  = 1'b0;
                len_next = '0;
            end else begin
                hf_next    = 1'b1;
                len_next   = n_val[LEN_W-1:0];
                ready_next = 1'b0;
            end
        end else if (cmd.advance) begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            clean_reg <= '0;
            rlen_reg  <= '0;
            ovf_reg   <= 1'b0;
            ready_reg <= 1'b0;
            bank_reg  <= 1'b0;
            idx_reg   <= '0;
            len_reg   <= '0;
            hf_reg    <= 1'b0;
        end else begin
            fill_reg  <= fill_next;
            clean_reg <= clean_next;
            rlen_reg  <= rlen_next;
            ovf_reg   <= ovf_next;
            ready_reg <= ready_next;
            bank_reg  <= bank_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            hf_reg    <= hf_next;
        end
        c0_reg <= c0_next;
        c1_reg <= c1_next;
    end

    // one write port (assembly bank), one registered read port (published bank)
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[{bank_reg, fill_reg}] <= rx_b;
        end
        rdata_reg <= mem[{!bank_reg, idx_next}];
    end

    assign status.read_single = (limit == 8'd0) || !ready_reg || (n_val == 8'd0);
    assign status.last_char   = (8'(idx_reg) == 8'(len_reg) - 8'd1);

    assign m_tdata = {1'b0, (cmd.send_char ? len_reg : LEN_W'(0)),
                      (cmd.send_char ? rdata_reg : 8'd0)};
    assign m_tuser = {cmd.send_char, hf_reg};
    assign m_tlast = cmd.send_char ? status.last_char : 1'b1;

endmodule

[hdl/sclf_ctrl.sv]
// Controller: transaction sequencing state machine for the framer.
module sclf_ctrl import sclf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == CMD_READ) begin
                    state_next = status.read_single ? ST_SINGLE : ST_SEND;
                end
            end
            ST_SINGLE: begin
                if (m_tready) state_next = ST_IDLE;
            end
            ST_SEND: begin
                if (m_tready && status.last_char) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd.byte_en    = 1'b0;
        cmd.read_start = 1'b0;
        cmd.advance    = 1'b0;
        cmd.send_char  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.byte_en    = s_tvalid && (s_tuser == CMD_BYTE);
                cmd.read_start = s_tvalid && (s_tuser == CMD_READ);
            end
            ST_SINGLE: begin
                m_tvalid = 1'b1;
            end
            ST_SEND: begin
                m_tvalid      = 1'b1;
                cmd.send_char = 1'b1;
                cmd.advance   = m_tready && !status.last_char;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

[hdl/serial_command_line_framer_unit.sv]
// Top level of the serial command line framer: controller plus datapath.
//
//  channel | dir | tdata (low bit up)                  | tuser                        | tlast
//  s_      | in  | rx_byte[7:0], read_limit[15:8]      | cmd (0 byte, 1 read)         | -
//  m_      | out | line_char[7:0], frame_length[14:8], | line_found[0], char_valid[1] | last
//          |     | zero pad [15]                       |                              |
//
// A received byte is a single transaction; it gives no result.
// A read is accepted and then gives N result transactions, one per cycle while
// m_tready is high (N = returned characters, or 1 for an empty/refused read), paced by the
// registered read port of the line memory. While results are pending s_tready is low.
// Reset (aresetn low, synchronous) clears the state machine, counters and flags;
// the line memory keeps its contents and needs no clearing pass.
// A stall on m_tready holds the current result and the read index.
module serial_command_line_framer_unit import sclf_pkg::*; #(
    parameter int FRAME_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_limit[15:8]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // line_char[7:0], frame_length[14:8], pad[15]
    output logic [1:0]  m_tuser,   // line_found[0], char_valid[1]
    output logic        m_tlast    // last result of a read
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencing: accepts one transaction, then walks the read results
    sclf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // line assembly, publish by bank swap, and read-out fields
    sclf_dpath #(
        .FRAME_MAX (FRAME_MAX)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .status  (status),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
